>>> rtl/core/sqe_pkg.sv
package sqe_pkg;

    // Field widths of the stream payload.
    localparam int OP_W  = 3;
    localparam int ERR_W = 2;
    localparam int OUT_W = 32;

    // Operation codes carried by an input request.
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_DUMP = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 3'd2;
    localparam logic [OP_W-1:0] OP_POP  = 3'd3;
    localparam logic [OP_W-1:0] OP_SWAP = 3'd4;

    // Error codes returned with each result.
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SHORT = 2'd2;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd3;

    // Command broadcast to every cell of the chain.
    localparam int CMD_W = 3;
    typedef logic [CMD_W-1:0] cell_cmd_t;

    localparam cell_cmd_t CELL_HOLD       = 3'd0;
    localparam cell_cmd_t CELL_SHIFT_DOWN = 3'd1;
    localparam cell_cmd_t CELL_SHIFT_UP   = 3'd2;
    localparam cell_cmd_t CELL_LOAD_AT    = 3'd3;
    localparam cell_cmd_t CELL_SWAP       = 3'd4;
    localparam cell_cmd_t CELL_ROTATE     = 3'd5;

endpackage

>>> rtl/core/sqe_cell.sv
module sqe_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 6,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  sqe_pkg::cell_cmd_t    cmd,
    input  logic [IDX_W-1:0]      pos,
    input  logic [DATA_WIDTH-1:0] prev_data,
    input  logic [DATA_WIDTH-1:0] next_data,
    input  logic [DATA_WIDTH-1:0] head_data,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic [DATA_WIDTH-1:0] data
);
    import sqe_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // Select what this cell holds after the edge. Position 0 is the top.
    always_comb
    begin
        data_next = data_reg;
        case (cmd)
            CELL_SHIFT_DOWN:
            begin
                data_next = prev_data;
            end
            CELL_SHIFT_UP:
            begin
                data_next = next_data;
            end
            CELL_LOAD_AT:
            begin
                if (pos == MY_IDX)
                begin
                    data_next = push_data;
                end
            end
            CELL_SWAP:
            begin
                if (IDX == 0)
                begin
                    data_next = next_data;
                end
                else if (IDX == 1)
                begin
                    data_next = prev_data;
                end
            end
            CELL_ROTATE:
            begin
                // The occupied cells turn by one: the top goes to the bottom entry.
                if (pos == MY_IDX)
                begin
                    data_next = head_data;
                end
                else if (MY_IDX < pos)
                begin
                    data_next = next_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> rtl/core/stack_queue_engine.sv
// A result is registered in the cycle after its request is accepted.
// Push, pop, peek and swap each give one result; a dump gives one result per
// stored entry, as the chain of cells turns by one place a cycle while the result register is free.
// Reset clears the entry count and sets stack mode; stored entries are not cleared.
module stack_queue_engine #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] op, [34:3] push_value, [39:35] zero
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] read_value
    output logic [2:0]  m_tuser,   // [0] has_value, [2:1] error_code
    output logic        m_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sqe_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (DATA_WIDTH > OUT_W) ? DATA_WIDTH : OUT_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      rem_next;
    logic                  mode_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_W-1:0]      out_data_reg;
    logic [OUT_W-1:0]      out_data_next;
    logic                  out_has_reg;
    logic                  out_has_next;
    logic [ERR_W-1:0]      out_err_reg;
    logic [ERR_W-1:0]      out_err_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    logic [OP_W-1:0]       in_op;
    logic signed [OUT_W-1:0] in_value;
    logic signed [EXT_W-1:0] push_ext;
    logic [DATA_WIDTH-1:0] push_data;
    logic signed [EXT_W-1:0] head_ext;
    logic [OUT_W-1:0]      head_value;
    logic                  accept;
    logic                  out_free;
    logic                  cfg_write;

    cell_cmd_t             cmd;
    logic [IDX_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];

    // Request fields and width conversion of stored values.
    assign in_op      = s_tdata[2:0];
    assign in_value   = s_tdata[34:3];
    assign push_ext   = EXT_W'(in_value);
    assign push_data  = push_ext[DATA_WIDTH-1:0];
    assign head_ext   = EXT_W'($signed(cell_data[0]));
    assign head_value = head_ext[OUT_W-1:0];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Chain of cells; cell 0 holds the top entry.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] prev_data;
        logic [DATA_WIDTH-1:0] next_data;

        if (g == 0)
        begin : g_first
            assign prev_data = push_data;
        end
        else
        begin : g_mid_prev
            assign prev_data = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign next_data = '0;
        end
        else
        begin : g_mid_next
            assign next_data = cell_data[g+1];
        end

        sqe_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .IDX        (g)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .pos       (pos),
            .prev_data (prev_data),
            .next_data (next_data),
            .head_data (cell_data[0]),
            .push_data (push_data),
            .data      (cell_data[g])
        );
    end

    // Operation control and result selection.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        cmd            = CELL_HOLD;
        pos            = '0;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_has_next   = out_has_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_has_next   = 1'b0;
                    out_err_next   = ERR_OK;
                    out_last_next  = 1'b1;
                    case (in_op)
                        OP_PUSH:
                        begin
                            if (count_reg == CNT_FULL)
                            begin
                                out_err_next = ERR_FULL;
                            end
                            else
                            begin
                                if (mode_reg)
                                begin
                                    cmd = CELL_SHIFT_DOWN;
                                end
                                else
                                begin
                                    cmd = CELL_LOAD_AT;
                                    pos = count_reg[IDX_W-1:0];
                                end
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (count_reg != '0)
                            begin
                                out_data_next = head_value;
                                out_has_next  = 1'b1;
                                out_last_next = (count_reg == CNT_ONE);
                                cmd           = CELL_ROTATE;
                                pos           = IDX_W'(count_reg - CNT_ONE);
                                rem_next      = count_reg - CNT_ONE;
                                if (count_reg != CNT_ONE)
                                begin
                                    state_next = ST_DUMP;
                                end
                            end
                        end
                        OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                out_err_next = ERR_EMPTY;
                            end
                            else
                            begin
                                out_data_next = head_value;
                                out_has_next  = 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_err_next = ERR_EMPTY;
                            end
                            else
                            begin
                                cmd        = CELL_SHIFT_UP;
                                count_next = count_reg - CNT_ONE;
                            end
                        end
                        OP_SWAP:
                        begin
                            if (count_reg < CNT_TWO)
                            begin
                                out_err_next = ERR_SHORT;
                            end
                            else
                            begin
                                cmd = CELL_SWAP;
                            end
                        end
                        default:
                        begin
                            out_err_next = ERR_OK;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                // One entry leaves the top each time the result register is free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = head_value;
                    out_has_next   = 1'b1;
                    out_err_next   = ERR_OK;
                    out_last_next  = (rem_reg == CNT_ONE);
                    cmd            = CELL_ROTATE;
                    pos            = IDX_W'(count_reg - CNT_ONE);
                    rem_next       = rem_reg - CNT_ONE;
                    if (rem_reg == CNT_ONE)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_has_reg  <= out_has_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
    end

    // Configuration register: stack mode at address 0.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            mode_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr == 2'd0) ? {31'd0, mode_reg} : 32'd0;

    // Output stream.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_err_reg, out_has_reg};
    assign m_tlast  = out_last_reg;

endmodule
